### src/lbs_pkg.sv
// Shared types and constants for the linear blend skinning block.
// No dependencies; imported by lbs_bone_mem and linear_blend_skinning.
package lbs_pkg;

    // Matrix layout: 3 rows of 4 Q16.16 words per bone
    localparam int ROWS_PER_BONE  = 3;
    localparam int COLS_PER_ROW   = 4;
    localparam int ELEMS_PER_BONE = ROWS_PER_BONE * COLS_PER_ROW;

    localparam logic [15:0] WEIGHT_ONE = 16'h8000;

    // Request kinds carried on tuser
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_WEIGHT = 1'b1;

    // Register index decoded from paddr[2]
    localparam logic REG_BONE_COUNT = 1'b0;

    // Arithmetic widths
    localparam int PROD_W = 64;  // 32x32 product
    localparam int SUM_W  = 66;  // sum of three products
    localparam int T_W    = 51;  // row result after shift and translation
    localparam int TW_W   = 68;  // row result times weight
    localparam int CTB_W  = 53;  // weighted row result after the Q1.15 shift
    localparam int ACC_W  = 64;

    typedef logic signed [31:0] word_t;
    typedef word_t mat_row_t [COLS_PER_ROW];

endpackage

### src/linear_blend_skinning.sv
// Linear blend skinning top level: stream ports, APB register, row pipeline.
// Depends on lbs_pkg and lbs_bone_mem.
//
// The s_ stream carries requests; tuser[0] selects the kind. A load request
// writes one Q16.16 element of a bone's 3x4 matrix, a weight request applies
// one Q1.15 bone weight to the vertex position it carries. tlast marks the
// final weight of a vertex: that request produces one m_ result with the
// saturated x, y, z sums and a saturation flag, and clears the sums.
// The APB register bone_count (address 0) sets how many bones are in use;
// weights for bones outside that range contribute nothing.
// A load or a skipped weight reads no rows. For a weight for a bone in use,
// three matrix rows are read one per cycle and each passes a 4-stage
// pipeline (multiply, sum, weight multiply, accumulate); the next request
// waits until the last row is accumulated. A last weight also moves the
// sums into the output register.
// Reset: aresetn clears the sums, bone_count and the handshakes and holds
// s_tready low. The bone memory is not cleared; load every element first.
// Stalls: the result waits in the output register while m_tready is low;
// requests without a result keep flowing, the next last weight holds.
module linear_blend_skinning
    import lbs_pkg::*;
#(
    parameter int MAX_BONES = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    // request stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // [7:0] bone_index, [11:8] element, [43:12] matrix_value, [59:44] weight,
    // [91:60] pos_x, [123:92] pos_y, [155:124] pos_z, [159:156] zero
    input  logic [159:0] s_tdata,
    input  logic [0:0]   s_tuser,  // [0] cmd
    input  logic         s_tlast,  // last_weight
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] out_x, [63:32] out_y, [95:64] out_z
    output logic [95:0]  m_tdata,
    output logic [0:0]   m_tuser,  // [0] saturated
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int ROWS = MAX_BONES * ROWS_PER_BONE;
    localparam int AW   = $clog2(ROWS);
    localparam logic [7:0] MAX_BONES_B = 8'(MAX_BONES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_EMIT
    } state_t;

    // ---------------------------------------------------------------
    // Request field unpacking
    // ---------------------------------------------------------------
    logic               in_cmd;
    logic signed [7:0]  in_bone;
    logic [3:0]         in_element;
    word_t              in_value;
    logic [15:0]        in_weight;
    word_t              in_pos [ROWS_PER_BONE];

    assign in_cmd     = s_tuser[0];
    assign in_bone    = s_tdata[7:0];
    assign in_element = s_tdata[11:8];
    assign in_value   = s_tdata[43:12];
    assign in_weight  = s_tdata[59:44];
    assign in_pos[0]  = s_tdata[91:60];
    assign in_pos[1]  = s_tdata[123:92];
    assign in_pos[2]  = s_tdata[155:124];

    // ---------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------
    logic [6:0] bone_count_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BONE_COUNT) ? {25'd0, bone_count_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bone_count_reg <= 7'd0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_BONE_COUNT) begin
            bone_count_reg <= pwdata[6:0];
        end
    end

    // ---------------------------------------------------------------
    // Request decode
    // ---------------------------------------------------------------
    state_t         state_reg;
    logic           accept;
    logic           bone_in_mem;
    logic           load_ok;
    logic           weight_hit;
    logic [AW-1:0]  in_row_base;
    logic [AW-1:0]  wr_addr;
    logic [8:0]     base_wide;

    assign s_tready    = aresetn && (state_reg == ST_IDLE);
    assign accept      = s_tvalid && s_tready;
    assign bone_in_mem = !in_bone[7] && ({1'b0, in_bone[6:0]} < MAX_BONES_B);
    assign load_ok     = bone_in_mem && (in_element < 4'(ELEMS_PER_BONE));
    assign weight_hit  = bone_in_mem && (in_bone[6:0] < bone_count_reg);

    // bone * 3 as shift and add
    assign base_wide   = {2'b00, in_bone[6:0]} + {1'b0, in_bone[6:0], 1'b0};
    assign in_row_base = AW'(base_wide);
    assign wr_addr     = AW'(base_wide + {7'd0, in_element[3:2]});

    // ---------------------------------------------------------------
    // Bone matrix memory
    // ---------------------------------------------------------------
    logic           mem_wr_en;
    logic           mem_rd_en;
    logic [AW-1:0]  mem_rd_addr;
    mat_row_t       mem_q;
    logic [AW-1:0]  base_reg;
    logic [1:0]     issue_cnt_reg;

    assign mem_wr_en = accept && (in_cmd == CMD_LOAD) && load_ok;

    always_comb begin
        mem_rd_en   = 1'b0;
        mem_rd_addr = in_row_base;
        if (accept && in_cmd == CMD_WEIGHT && weight_hit) begin
            mem_rd_en = 1'b1;
        end else if (state_reg == ST_RUN && issue_cnt_reg != 2'd3) begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = AW'(base_reg + AW'(issue_cnt_reg));
        end
    end

    lbs_bone_mem #(
        .ROWS (ROWS)
    ) u_bone_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (wr_addr),
        .wr_col  (in_element[1:0]),
        .wr_data (in_value),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_q)
    );

    // ---------------------------------------------------------------
    // Row pipeline: A = row read out, B = products, C = row result,
    // D = weighted row result, then accumulate
    // ---------------------------------------------------------------
    word_t                   pos_reg [ROWS_PER_BONE];
    logic [15:0]             w_reg;
    logic                    last_reg;

    logic                    va_reg, vb_reg, vc_reg, vd_reg;
    logic [1:0]              row_a_reg, row_b_reg, row_c_reg, row_d_reg;
    logic signed [PROD_W-1:0] prod_reg [ROWS_PER_BONE];
    word_t                   trans_reg;
    logic signed [T_W-1:0]   t_reg;
    logic signed [TW_W-1:0]  tw_reg;
    logic signed [ACC_W-1:0] acc_reg [ROWS_PER_BONE];

    logic signed [SUM_W-1:0] sum_next;
    logic signed [T_W-1:0]   t_next;
    logic signed [TW_W-1:0]  tw_next;
    logic signed [CTB_W-1:0] ctb;
    logic signed [ACC_W:0]   acc_sum;
    logic signed [ACC_W-1:0] acc_next;

    assign sum_next = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]) + SUM_W'(prod_reg[2]);
    assign t_next   = T_W'(sum_next >>> 16) + T_W'(trans_reg);
    assign tw_next  = TW_W'(t_reg) * TW_W'($signed({1'b0, w_reg}));
    assign ctb      = CTB_W'(tw_reg >>> 15);
    assign acc_sum  = (ACC_W + 1)'(acc_reg[row_d_reg]) + (ACC_W + 1)'(ctb);

    // clamp at the 64-bit limits
    always_comb begin
        if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
            acc_next = acc_sum[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}}
                                      : {1'b0, {(ACC_W - 1){1'b1}}};
        end else begin
            acc_next = acc_sum[ACC_W-1:0];
        end
    end

    // payload: no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            pos_reg  <= in_pos;
            w_reg    <= (in_weight > WEIGHT_ONE) ? WEIGHT_ONE : in_weight;
            last_reg <= s_tlast;
            base_reg <= in_row_base;
        end
        if (va_reg) begin
            for (int c = 0; c < ROWS_PER_BONE; c++) begin
                prod_reg[c] <= PROD_W'(mem_q[c]) * PROD_W'(pos_reg[c]);
            end
            trans_reg <= mem_q[COLS_PER_ROW-1];
            row_b_reg <= row_a_reg;
        end
        if (vb_reg) begin
            t_reg     <= t_next;
            row_c_reg <= row_b_reg;
        end
        if (vc_reg) begin
            tw_reg    <= tw_next;
            row_d_reg <= row_c_reg;
        end
    end

    // ---------------------------------------------------------------
    // Emit: clip each sum to 32 bits
    // ---------------------------------------------------------------
    word_t out_word [ROWS_PER_BONE];
    logic  out_clip [ROWS_PER_BONE];

    always_comb begin
        for (int r = 0; r < ROWS_PER_BONE; r++) begin
            out_clip[r] = (acc_reg[r][ACC_W-1:31] != {(ACC_W - 31){1'b0}}) &&
                          (acc_reg[r][ACC_W-1:31] != {(ACC_W - 31){1'b1}});
            if (out_clip[r]) begin
                out_word[r] = acc_reg[r][ACC_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
            end else begin
                out_word[r] = acc_reg[r][31:0];
            end
        end
    end

    // ---------------------------------------------------------------
    // Control: state, row issue, stage valids, sums, output register
    // ---------------------------------------------------------------
    logic        m_tvalid_reg;
    logic [95:0] m_tdata_reg;
    logic        m_sat_reg;
    logic        pipe_busy;
    logic        out_free;

    assign pipe_busy = va_reg || vb_reg || vc_reg || vd_reg;
    assign out_free  = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            issue_cnt_reg <= 2'd0;
            va_reg        <= 1'b0;
            vb_reg        <= 1'b0;
            vc_reg        <= 1'b0;
            vd_reg        <= 1'b0;
            row_a_reg     <= 2'd0;
            m_tvalid_reg  <= 1'b0;
            for (int r = 0; r < ROWS_PER_BONE; r++) begin
                acc_reg[r] <= '0;
            end
        end else begin
            // advance the row pipeline; a row enters whenever one is read
            va_reg <= mem_rd_en;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
            if (vd_reg) begin
                acc_reg[row_d_reg] <= acc_next;
            end
            // drop the result once taken, unless a new one replaces it
            if (m_tvalid_reg && m_tready && state_reg != ST_EMIT) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (accept && in_cmd == CMD_WEIGHT) begin
                        if (weight_hit) begin
                            row_a_reg     <= 2'd0;
                            issue_cnt_reg <= 2'd1;
                            state_reg     <= ST_RUN;
                        end else if (s_tlast) begin
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_RUN: begin
                    if (issue_cnt_reg != 2'd3) begin
                        row_a_reg     <= issue_cnt_reg;
                        issue_cnt_reg <= issue_cnt_reg + 2'd1;
                    end else if (!pipe_busy) begin
                        state_reg <= last_reg ? ST_EMIT : ST_IDLE;
                    end
                end
                ST_EMIT: begin
                    // hold until the output register frees
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {out_word[2], out_word[1], out_word[0]};
                        m_sat_reg    <= out_clip[0] || out_clip[1] || out_clip[2];
                        for (int r = 0; r < ROWS_PER_BONE; r++) begin
                            acc_reg[r] <= '0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_sat_reg;

`ifndef SYNTH
    // a new request never enters while rows are in flight
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !pipe_busy)
        else $error("request accepted with rows in flight");

    // a hit weight starts row 0 in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_cmd == CMD_WEIGHT && weight_hit) |=> (va_reg && row_a_reg == 2'd0))
        else $error("row 0 not issued after weight request");

    // emit waits while the output register is full and stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && m_tvalid_reg && !m_tready) |=> (state_reg == ST_EMIT))
        else $error("result overwritten while stalled");

    // at most three rows in the pipeline
    assert property (@(posedge aclk) disable iff (!aresetn)
        $countones({va_reg, vb_reg, vc_reg, vd_reg}) <= 3)
        else $error("more rows in flight than a matrix has");

    // rows are only issued in the idle or run state
    assert property (@(posedge aclk) disable iff (!aresetn)
        va_reg |-> $past(state_reg == ST_IDLE || state_reg == ST_RUN))
        else $error("row issued outside a weight request");
`endif

endmodule

### src/lbs_bone_mem.sv
// Bone matrix memory: one row of four words per address, word-wide writes.
// Depends on lbs_pkg for the row type.
module lbs_bone_mem
    import lbs_pkg::*;
#(
    parameter int ROWS = 192
) (
    input  logic                    aclk,
    input  logic                    wr_en,
    input  logic [$clog2(ROWS)-1:0] wr_addr,
    input  logic [1:0]              wr_col,
    input  word_t                   wr_data,
    input  logic                    rd_en,
    input  logic [$clog2(ROWS)-1:0] rd_addr,
    output mat_row_t                rd_data
);

    word_t mem [ROWS][COLS_PER_ROW];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr][wr_col] <= wr_data;
        end
    end

    // registered read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
